// ===== rtl/core/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// dq_pkg
// Shared operation codes, status codes and controller/datapath signal groups
// for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

	// Operation carried by each input beat.
	typedef enum logic [1:0] {
		ACT_PUSH_FRONT = 2'd0,
		ACT_PUSH_BACK  = 2'd1,
		ACT_POP_FRONT  = 2'd2,
		ACT_POP_BACK   = 2'd3
	} dq_action_t;

	// Status returned with each result beat.
	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} dq_status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic exec;
		logic read;
		logic load;
	} dq_cmd_t;

	// Occupancy status from the datapath.
	typedef struct packed {
		logic full;
		logic empty;
	} dq_stat_t;

endpackage

// ===== rtl/core/double_ended_queue.sv =====
// Each operation passes through the capture, execute, memory read and result
// load steps of the controller, and a new operation is accepted only once the
// last one has been loaded; a waiting result stalls the load step only.
// Reset (arst_n low) clears the indices, the entry count, the controller and
// the result-valid flag at once; the entry store is not cleared.
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed 32-bit words held in a circular store.
// ----------------------------------------------------------------------------
module double_ended_queue
	import dq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream: one operation per beat.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] item_value
	input  logic [1:0]  s_tuser,   // [1:0] action
	// Result stream: one result per operation.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // [31:0] front_value, [32] is_empty, [34:33] status
);

	dq_cmd_t     cmd;
	dq_stat_t    stat;
	logic [31:0] front_value;
	logic        is_empty;
	logic [1:0]  status;

	// The controller walks one operation through its steps and holds off the
	// input until the result has been placed in the output register.
	dq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	// The datapath owns the store, the indices, the count and the result.
	dq_datapath #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.in_action   (s_tuser),
		.in_value    (s_tdata),
		.stat        (stat),
		.front_value (front_value),
		.is_empty    (is_empty),
		.status      (status)
	);

	// Result beat packing, lowest field first, padded to whole bytes.
	assign m_tdata = {5'd0, status, is_empty, front_value};

`ifndef SYNTHESIS
	// An empty queue reports a zero front.
	a_empty_front_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[32] |-> m_tdata[31:0] == 32'd0)
		else $error("empty result with nonzero front");

	// Only one operation is in flight at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an operation is in flight");

	// Occupancy can never be both full and empty.
	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		!(stat.full && stat.empty))
		else $error("queue reports full and empty");

	// Status codes are always one of the defined ones.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[34:33] == STAT_DONE || m_tdata[34:33] == STAT_FULL
			|| m_tdata[34:33] == STAT_EMPTY))
		else $error("undefined status code");
`endif

endmodule

// ===== rtl/core/dq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer for one operation at a time: capture, execute, read, load.
// Also owns the result-valid flag of the output register.
// ----------------------------------------------------------------------------
module dq_ctrl
	import dq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dq_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_READ = 4'b0100,
		S_LOAD = 4'b1000
	} dq_state_t;

	dq_state_t state_q;
	logic      out_valid_q;
	logic      load_ok;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign load_ok   = (state_q == S_LOAD) && (!out_valid_q || out_ready);

	assign cmd.capture = in_valid && in_ready;
	assign cmd.exec    = (state_q == S_EXEC);
	assign cmd.read    = (state_q == S_READ);
	assign cmd.load    = load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_EXEC;
				end
				S_EXEC: state_q <= S_READ;
				S_READ: state_q <= S_LOAD;
				S_LOAD: begin
					if (load_ok) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase

			// The result register fills on load and drains when the sink takes it.
			if (load_ok) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/dq_datapath.sv =====
// ----------------------------------------------------------------------------
// dq_datapath
// Circular entry store with front index, back index and entry count, plus
// the operand and result registers.
// ----------------------------------------------------------------------------
module dq_datapath
	import dq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dq_cmd_t     cmd,
	input  logic [1:0]  in_action,
	input  logic [31:0] in_value,
	output dq_stat_t    stat,
	output logic [31:0] front_value,
	output logic        is_empty,
	output logic [1:0]  status
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [31:0] mem [DEPTH];

	dq_action_t  act_q;
	logic [31:0] val_q;
	logic [AW-1:0] head_q, tail_q;
	logic [CW-1:0] count_q;
	dq_status_t  stat_q;
	logic [31:0] rd_q;
	logic [31:0] front_q;
	logic        empty_q;
	logic [1:0]  status_q;

	logic [AW-1:0] head_d, tail_d, waddr;
	logic [CW-1:0] count_d;
	dq_status_t    stat_d;
	logic          we;

	function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
		return (i == LAST_IDX) ? '0 : i + AW'(1);
	endfunction

	function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
		return (i == '0) ? LAST_IDX : i - AW'(1);
	endfunction

	assign stat.full  = (count_q == FULL_CNT);
	assign stat.empty = (count_q == '0);

	always_comb begin
		head_d  = head_q;
		tail_d  = tail_q;
		count_d = count_q;
		stat_d  = STAT_DONE;
		we      = 1'b0;
		waddr   = tail_q;
		case (act_q)
			ACT_PUSH_FRONT: begin
				if (stat.full) begin
					stat_d = STAT_FULL;
				end else begin
					head_d  = idx_dec(head_q);
					waddr   = head_d;
					we      = 1'b1;
					count_d = count_q + CW'(1);
				end
			end
			ACT_PUSH_BACK: begin
				if (stat.full) begin
					stat_d = STAT_FULL;
				end else begin
					waddr   = tail_q;
					we      = 1'b1;
					tail_d  = idx_inc(tail_q);
					count_d = count_q + CW'(1);
				end
			end
			ACT_POP_FRONT: begin
				if (stat.empty) begin
					stat_d = STAT_EMPTY;
				end else begin
					head_d  = idx_inc(head_q);
					count_d = count_q - CW'(1);
				end
			end
			default: begin
				if (stat.empty) begin
					stat_d = STAT_EMPTY;
				end else begin
					tail_d  = idx_dec(tail_q);
					count_d = count_q - CW'(1);
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (cmd.exec) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
		end
	end

	// Operand, status and result registers carry payload only.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q <= dq_action_t'(in_action);
			val_q <= in_value;
		end
		if (cmd.exec) stat_q <= stat_d;
		if (cmd.load) begin
			front_q  <= stat.empty ? 32'd0 : rd_q;
			empty_q  <= stat.empty;
			status_q <= stat_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && we) mem[waddr] <= val_q;
		if (cmd.read) rd_q <= mem[head_q];
	end

	assign front_value = front_q;
	assign is_empty    = empty_q;
	assign status      = status_q;

endmodule
